// ===== src/phsc_pkg.sv =====
// ----------------------------------------------------------------------------
// phsc_pkg
// Shared types and constants for the pump hysteresis safety controller.
// ----------------------------------------------------------------------------
`default_nettype none

package phsc_pkg;

  localparam int RAW_W      = 12;
  localparam int PCT_W      = 7;
  localparam int CENTI_W    = 11;
  localparam int TIME_W     = 32;
  localparam int FAULT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Divider: dividend up to 400*4095 + 300*4095 in magnitude, divisor 12 bits
  localparam int DIV_W = 22;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
  localparam logic [CENTI_W-1:0] CENTI_MAX = 11'd1400;
  localparam int PH_AT_4_CENTI = 400;
  localparam int PH_STEP_CENTI = 300;

  // Item kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_SENSOR  = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_WATER   = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_ESTOP   = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_RUNTIME = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_MIN          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_MAX          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOIST_DRY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOIST_WET       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_RAW_4        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_RAW_7        = 3'd7;

  // Register reset values
  localparam logic [PCT_W-1:0]   RST_MOISTURE_MIN    = 7'd45;
  localparam logic [PCT_W-1:0]   RST_MOISTURE_TARGET = 7'd65;
  localparam logic [CENTI_W-1:0] RST_PH_MIN          = 11'd550;
  localparam logic [CENTI_W-1:0] RST_PH_MAX          = 11'd700;
  localparam logic [RAW_W-1:0]   RST_MOIST_DRY       = 12'd3000;
  localparam logic [RAW_W-1:0]   RST_MOIST_WET       = 12'd1200;
  localparam logic [RAW_W-1:0]   RST_PH_RAW_4        = 12'd2032;
  localparam logic [RAW_W-1:0]   RST_PH_RAW_7        = 12'd1500;

  typedef struct packed {
    logic              kind;
    logic [RAW_W-1:0]  moisture_raw;
    logic [RAW_W-1:0]  ph_raw;
    logic              sensor_fault;
    logic              water_ok;
    logic [TIME_W-1:0] time_ms;
    logic              has_mode;
    logic              mode_manual;
    logic              has_pump_cmd;
    logic              pump_cmd_on;
    logic              estop;
  } item_t;

  typedef struct packed {
    logic [PCT_W-1:0]   moisture_pct;
    logic [CENTI_W-1:0] ph_centi;
    logic               ph_ok;
    logic               pump_on;
    logic               manual_active;
    logic [FAULT_W-1:0] fault_code;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic ctl_apply;
    logic m_load;
    logic p_load;
    logic div_step;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/phsc_item_if.sv =====
// ----------------------------------------------------------------------------
// phsc_item_if
// Input channel: valid/ready handshake with sample and control fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface phsc_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] moisture_raw;
  logic [11:0] ph_raw;
  logic        sensor_fault;
  logic        water_ok;
  logic [31:0] time_ms;
  logic        has_mode;
  logic        mode_manual;
  logic        has_pump_cmd;
  logic        pump_cmd_on;
  logic        estop;

  modport source (
    output valid, kind, moisture_raw, ph_raw, sensor_fault, water_ok, time_ms,
           has_mode, mode_manual, has_pump_cmd, pump_cmd_on, estop,
    input  ready
  );

  modport sink (
    input  valid, kind, moisture_raw, ph_raw, sensor_fault, water_ok, time_ms,
           has_mode, mode_manual, has_pump_cmd, pump_cmd_on, estop,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/phsc_result_if.sv =====
// ----------------------------------------------------------------------------
// phsc_result_if
// Output channel: valid/ready handshake with one controller result.
// ----------------------------------------------------------------------------
`default_nettype none

interface phsc_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  moisture_pct;
  logic [10:0] ph_centi;
  logic        ph_ok;
  logic        pump_on;
  logic        manual_active;
  logic [2:0]  fault_code;

  modport source (
    output valid, moisture_pct, ph_centi, ph_ok, pump_on, manual_active, fault_code,
    input  ready
  );

  modport sink (
    input  valid, moisture_pct, ph_centi, ph_ok, pump_on, manual_active, fault_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/phsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// phsc_ctrl
// Sequencer: accepts items, runs the two calibration divisions, commits.
// ----------------------------------------------------------------------------
`default_nettype none

module phsc_ctrl
  import phsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_kind,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD_M = 6'b000010,
    ST_DIV_M  = 6'b000100,
    ST_LOAD_P = 6'b001000,
    ST_DIV_P  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_CONTROL) begin
            cmd.ctl_apply = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_LOAD_M;
          end
        end
      end
      ST_LOAD_M: begin
        cmd.m_load = 1'b1;
        state_next = ST_DIV_M;
      end
      ST_DIV_M: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_LOAD_P;
      end
      ST_LOAD_P: begin
        cmd.p_load = 1'b1;
        state_next = ST_DIV_P;
      end
      ST_DIV_P: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/phsc_dp.sv =====
// ----------------------------------------------------------------------------
// phsc_dp
// Datapath: registers, calibration with a shared restoring divider,
// pump decision, runtime limit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module phsc_dp
  import phsc_pkg::*;
#(
  parameter logic [TIME_W-1:0] MAX_RUN_MS = 32'd300000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire item_t                 item_in,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output result_t                    out_data
);

  localparam logic signed [DIV_W:0] K_BASE = (DIV_W+1)'(PH_AT_4_CENTI);
  localparam logic signed [DIV_W:0] K_STEP = (DIV_W+1)'(PH_STEP_CENTI);

  // Configuration
  logic [PCT_W-1:0]   moisture_min, moisture_target;
  logic [CENTI_W-1:0] ph_min_centi, ph_max_centi;
  logic [RAW_W-1:0]   m_dry_cal, m_wet_cal, ph_raw_at_4, ph_raw_at_7;

  // Controller state
  logic              pump_running, manual_flag, manual_pump_cmd, estop_pending;
  logic [TIME_W-1:0] pump_start_ms;

  // Captured sample
  logic [RAW_W-1:0]  smp_moist_raw, smp_ph_raw;
  logic              smp_fault, smp_water;
  logic [TIME_W-1:0] smp_time;

  // Divider
  logic [DIV_W-1:0] div_q;
  logic [RAW_W-1:0] div_rem, div_den;
  logic [CNT_W-1:0] div_cnt;
  logic             m_zero, p_zero;
  logic [PCT_W-1:0] moist_q;

  // ---------------------------------------------------------------- setup
  logic signed [RAW_W:0] m_d, m_span, p_d, p_span;
  logic [RAW_W-1:0]      m_d_abs, m_span_abs, p_span_abs;
  logic [DIV_W-1:0]      m_num, p_num_abs;
  logic signed [DIV_W:0] p_span_ext, p_d_ext, p_num;
  logic                  m_zero_c, p_zero_c;

  always_comb begin
    m_d        = $signed({1'b0, smp_moist_raw}) - $signed({1'b0, m_dry_cal});
    m_span     = $signed({1'b0, m_wet_cal}) - $signed({1'b0, m_dry_cal});
    m_d_abs    = m_d[RAW_W] ? RAW_W'(-m_d) : m_d[RAW_W-1:0];
    m_span_abs = m_span[RAW_W] ? RAW_W'(-m_span) : m_span[RAW_W-1:0];
    m_num      = DIV_W'(m_d_abs) * DIV_W'(PCT_MAX);
    // negative quotient or zero span clamps to zero
    m_zero_c   = (m_span == '0) || (m_d[RAW_W] != m_span[RAW_W]);

    p_d        = $signed({1'b0, smp_ph_raw}) - $signed({1'b0, ph_raw_at_4});
    p_span     = $signed({1'b0, ph_raw_at_7}) - $signed({1'b0, ph_raw_at_4});
    p_span_abs = p_span[RAW_W] ? RAW_W'(-p_span) : p_span[RAW_W-1:0];
    p_span_ext = {{(DIV_W-RAW_W){p_span[RAW_W]}}, p_span};
    p_d_ext    = {{(DIV_W-RAW_W){p_d[RAW_W]}}, p_d};
    p_num      = p_span_ext * K_BASE + p_d_ext * K_STEP;
    p_num_abs  = p_num[DIV_W] ? DIV_W'(-p_num) : p_num[DIV_W-1:0];
    p_zero_c   = (p_span == '0) || (p_num[DIV_W] != p_span[RAW_W]);
  end

  // ---------------------------------------------------------------- divide
  logic [RAW_W:0]   trial, diff;
  logic             fits;
  logic [RAW_W-1:0] rem_step;

  always_comb begin
    trial    = {div_rem, div_q[DIV_W-1]};
    fits     = trial >= {1'b0, div_den};
    diff     = trial - {1'b0, div_den};
    rem_step = fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
  end

  assign status.div_last = (div_cnt == CNT_W'(DIV_W - 1));
  assign status.out_free = !out_valid || out_ready;

  // ---------------------------------------------------------------- clamp
  logic [PCT_W-1:0]   moist_val;
  logic [CENTI_W-1:0] ph_val;

  always_comb begin
    if (m_zero) moist_val = '0;
    else if (div_q > DIV_W'(PCT_MAX)) moist_val = PCT_MAX;
    else moist_val = div_q[PCT_W-1:0];

    if (p_zero) ph_val = '0;
    else if (div_q > DIV_W'(CENTI_MAX)) ph_val = CENTI_MAX;
    else ph_val = div_q[CENTI_W-1:0];
  end

  // ---------------------------------------------------------------- decide
  logic               want, force_off, run_pre, run_final, trip;
  logic [TIME_W-1:0]  start_pre, elapsed;
  logic [FAULT_W-1:0] fault_pre, fault_final;

  always_comb begin
    if (manual_flag) want = manual_pump_cmd;
    else if (smp_fault) want = 1'b0;
    else if (moist_q < moisture_min) want = 1'b1;
    else if (moist_q >= moisture_target) want = 1'b0;
    else want = pump_running;

    force_off = smp_fault || !smp_water || estop_pending;
    if (estop_pending) fault_pre = FAULT_ESTOP;
    else if (!smp_water) fault_pre = FAULT_WATER;
    else if (smp_fault) fault_pre = FAULT_SENSOR;
    else fault_pre = FAULT_NONE;

    run_pre   = !force_off && want;
    start_pre = (run_pre && !pump_running) ? smp_time : pump_start_ms;
    elapsed   = smp_time - start_pre;
    trip      = run_pre && (elapsed >= MAX_RUN_MS);

    run_final   = run_pre && !trip;
    fault_final = trip ? FAULT_RUNTIME : fault_pre;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      moisture_min    <= RST_MOISTURE_MIN;
      moisture_target <= RST_MOISTURE_TARGET;
      ph_min_centi    <= RST_PH_MIN;
      ph_max_centi    <= RST_PH_MAX;
      m_dry_cal       <= RST_MOIST_DRY;
      m_wet_cal       <= RST_MOIST_WET;
      ph_raw_at_4     <= RST_PH_RAW_4;
      ph_raw_at_7     <= RST_PH_RAW_7;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MOISTURE_MIN:    moisture_min    <= wr_data[PCT_W-1:0];
        CFG_MOISTURE_TARGET: moisture_target <= wr_data[PCT_W-1:0];
        CFG_PH_MIN:          ph_min_centi    <= wr_data[CENTI_W-1:0];
        CFG_PH_MAX:          ph_max_centi    <= wr_data[CENTI_W-1:0];
        CFG_MOIST_DRY:       m_dry_cal       <= wr_data[RAW_W-1:0];
        CFG_MOIST_WET:       m_wet_cal       <= wr_data[RAW_W-1:0];
        CFG_PH_RAW_4:        ph_raw_at_4     <= wr_data[RAW_W-1:0];
        CFG_PH_RAW_7:        ph_raw_at_7     <= wr_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_running    <= 1'b0;
      manual_flag     <= 1'b0;
      manual_pump_cmd <= 1'b0;
      estop_pending   <= 1'b0;
      pump_start_ms   <= '0;
    end else if (cmd.ctl_apply) begin
      if (item_in.has_mode) manual_flag <= item_in.mode_manual;
      if (item_in.has_pump_cmd) manual_pump_cmd <= item_in.pump_cmd_on;
      if (item_in.estop) estop_pending <= 1'b1;
    end else if (cmd.commit) begin
      pump_running  <= run_final;
      pump_start_ms <= run_final ? start_pre : '0;
      estop_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_moist_raw <= item_in.moisture_raw;
      smp_ph_raw    <= item_in.ph_raw;
      smp_fault     <= item_in.sensor_fault;
      smp_water     <= item_in.water_ok;
      smp_time      <= item_in.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.m_load || cmd.p_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.m_load) begin
      div_q   <= m_num;
      div_den <= m_span_abs;
      div_rem <= '0;
      m_zero  <= m_zero_c;
    end else if (cmd.p_load) begin
      moist_q <= moist_val;
      div_q   <= p_num_abs;
      div_den <= p_span_abs;
      div_rem <= '0;
      p_zero  <= p_zero_c;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[DIV_W-2:0], fits};
      div_rem <= rem_step;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.moisture_pct  <= moist_q;
      out_data.ph_centi      <= ph_val;
      out_data.ph_ok         <= (ph_val >= ph_min_centi) && (ph_val <= ph_max_centi);
      out_data.pump_on       <= run_final;
      out_data.manual_active <= manual_flag;
      out_data.fault_code    <= fault_final;
    end
  end

endmodule

`default_nettype wire

// ===== src/pump_hysteresis_safety_controller.sv =====
// Sample item: the result is registered on commit; the next item is taken
//   the cycle after the result is committed, so samples do not overlap.
// Each sample runs the shared restoring divider, 22 steps for moisture and
//   22 for pH, and commits once the result register is free or being read.
// Synchronous active-high reset restores register defaults, auto mode,
//   pump off, no pending stop; no result is pending after reset.
// ----------------------------------------------------------------------------
// pump_hysteresis_safety_controller
// Top level: hysteresis pump controller with calibration and safety overrides.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_hysteresis_safety_controller
  import phsc_pkg::*;
#(
  parameter logic [31:0] MAX_RUN_MS = 32'd300000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  phsc_item_if.sink                  item,
  phsc_result_if.source              result,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data
);

  cmd_t    cmd;
  status_t status;
  item_t   item_data;
  result_t result_data;

  assign item_data.kind         = item.kind;
  assign item_data.moisture_raw = item.moisture_raw;
  assign item_data.ph_raw       = item.ph_raw;
  assign item_data.sensor_fault = item.sensor_fault;
  assign item_data.water_ok     = item.water_ok;
  assign item_data.time_ms      = item.time_ms;
  assign item_data.has_mode     = item.has_mode;
  assign item_data.mode_manual  = item.mode_manual;
  assign item_data.has_pump_cmd = item.has_pump_cmd;
  assign item_data.pump_cmd_on  = item.pump_cmd_on;
  assign item_data.estop        = item.estop;

  phsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  phsc_dp #(
    .MAX_RUN_MS (MAX_RUN_MS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .item_in   (item_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result_data)
  );

  assign result.moisture_pct  = result_data.moisture_pct;
  assign result.ph_centi      = result_data.ph_centi;
  assign result.ph_ok         = result_data.ph_ok;
  assign result.pump_on       = result_data.pump_on;
  assign result.manual_active = result_data.manual_active;
  assign result.fault_code    = result_data.fault_code;

endmodule

`default_nettype wire

// ===== bench/phsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsc_checker
// Watches the item, result and register ports of the pump controller, keeps
// its own copy of the calibration registers and controller state, predicts
// each sample result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------

module phsc_checker
  import phsc_pkg::*;
#(
  parameter logic [31:0] RUN_LIMIT_MS = 32'd300000
) (
  input  logic                  clk,
  input  logic                  rst,
  phsc_item_if                  item,
  phsc_result_if                result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output int unsigned           pending,
  output int unsigned           errors
);

  // Register copies
  logic [PCT_W-1:0]   thr_min, thr_target;
  logic [CENTI_W-1:0] ph_lo, ph_hi;
  logic [RAW_W-1:0]   dry_raw, wet_raw, raw_at_4, raw_at_7;

  // Controller state
  logic               pump_run, manual_mode, manual_cmd, estop_armed;
  logic [TIME_W-1:0]  run_start;

  result_t            expected_q[$];
  int unsigned        fails = 0;

  function automatic result_t predict_sample(input item_t it);
    result_t            r;
    longint             lo, hi, raw, span, d, q;
    logic               want, was_on, force_off;
    logic [FAULT_W-1:0] fault;
    logic [TIME_W-1:0]  elapsed;

    lo   = dry_raw;
    hi   = wet_raw;
    raw  = it.moisture_raw;
    span = hi - lo;
    d    = raw - lo;
    if (span == 0) q = 0;
    else q = d * 100 / span;
    if (q < 0) q = 0;
    else if (q > 100) q = 100;
    r.moisture_pct = q[PCT_W-1:0];

    lo   = raw_at_4;
    hi   = raw_at_7;
    raw  = it.ph_raw;
    span = hi - lo;
    d    = raw - lo;
    // flat pH calibration reads as the lower clamp
    if (span == 0) q = 0;
    else q = (PH_AT_4_CENTI * span + PH_STEP_CENTI * d) / span;
    if (q < 0) q = 0;
    else if (q > 1400) q = 1400;
    r.ph_centi = q[CENTI_W-1:0];
    r.ph_ok    = (r.ph_centi >= ph_lo) && (r.ph_centi <= ph_hi);

    if (manual_mode) want = manual_cmd;
    else if (it.sensor_fault) want = 1'b0;
    else if (r.moisture_pct < thr_min) want = 1'b1;
    else if (r.moisture_pct >= thr_target) want = 1'b0;
    else want = pump_run;

    // later causes win: estop over low water over sensor fault
    force_off = 1'b0;
    fault     = FAULT_NONE;
    if (it.sensor_fault) begin
      force_off = 1'b1;
      fault     = FAULT_SENSOR;
    end
    if (!it.water_ok) begin
      force_off = 1'b1;
      fault     = FAULT_WATER;
    end
    if (estop_armed) begin
      force_off = 1'b1;
      fault     = FAULT_ESTOP;
    end

    was_on   = pump_run;
    pump_run = !force_off && want;
    if (pump_run && !was_on) run_start = it.time_ms;
    elapsed = it.time_ms - run_start;
    if (pump_run && elapsed >= RUN_LIMIT_MS) begin
      pump_run = 1'b0;
      fault    = FAULT_RUNTIME;
    end
    if (!pump_run) run_start = '0;
    estop_armed = 1'b0;

    r.pump_on       = pump_run;
    r.manual_active = manual_mode;
    r.fault_code    = fault;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    item_t   it;
    result_t got, want;
    if (rst) begin
      thr_min     = RST_MOISTURE_MIN;
      thr_target  = RST_MOISTURE_TARGET;
      ph_lo       = RST_PH_MIN;
      ph_hi       = RST_PH_MAX;
      dry_raw     = RST_MOIST_DRY;
      wet_raw     = RST_MOIST_WET;
      raw_at_4    = RST_PH_RAW_4;
      raw_at_7    = RST_PH_RAW_7;
      pump_run    = 1'b0;
      manual_mode = 1'b0;
      manual_cmd  = 1'b0;
      estop_armed = 1'b0;
      run_start   = '0;
      expected_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_MOISTURE_MIN:    thr_min    = wr_data[PCT_W-1:0];
          CFG_MOISTURE_TARGET: thr_target = wr_data[PCT_W-1:0];
          CFG_PH_MIN:          ph_lo      = wr_data[CENTI_W-1:0];
          CFG_PH_MAX:          ph_hi      = wr_data[CENTI_W-1:0];
          CFG_MOIST_DRY:       dry_raw    = wr_data[RAW_W-1:0];
          CFG_MOIST_WET:       wet_raw    = wr_data[RAW_W-1:0];
          CFG_PH_RAW_4:        raw_at_4   = wr_data[RAW_W-1:0];
          CFG_PH_RAW_7:        raw_at_7   = wr_data[RAW_W-1:0];
          default: ;
        endcase
      end

      // results first: a result never belongs to an item taken at the same edge
      if (result.valid && result.ready) begin
        got.moisture_pct  = result.moisture_pct;
        got.ph_centi      = result.ph_centi;
        got.ph_ok         = result.ph_ok;
        got.pump_on       = result.pump_on;
        got.manual_active = result.manual_active;
        got.fault_code    = result.fault_code;
        if (expected_q.size() == 0) begin
          fails++;
          $error("result transfer with no sample outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("moisture_pct", want.moisture_pct, got.moisture_pct);
          check_field("ph_centi", want.ph_centi, got.ph_centi);
          check_field("ph_ok", want.ph_ok, got.ph_ok);
          check_field("pump_on", want.pump_on, got.pump_on);
          check_field("manual_active", want.manual_active, got.manual_active);
          check_field("fault_code", want.fault_code, got.fault_code);
        end
      end

      if (item.valid && item.ready) begin
        if (item.kind == KIND_CONTROL) begin
          if (item.has_mode) manual_mode = item.mode_manual;
          if (item.has_pump_cmd) manual_cmd = item.pump_cmd_on;
          if (item.estop) estop_armed = 1'b1;
        end else begin
          it              = '0;
          it.kind         = item.kind;
          it.moisture_raw = item.moisture_raw;
          it.ph_raw       = item.ph_raw;
          it.sensor_fault = item.sensor_fault;
          it.water_ok     = item.water_ok;
          it.time_ms      = item.time_ms;
          expected_q.push_back(predict_sample(it));
        end
      end
    end
    pending <= expected_q.size();
    errors  <= fails;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the pump controller through directed samples and controls, then
// random phases under several calibration settings with random idling on
// both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb;
  import phsc_pkg::*;

  localparam logic [31:0] RUN_LIMIT_MS  = 32'd300000;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          DRAIN_CAP     = 20000;
  localparam int          HOLD_CYCLES   = 400;

  typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  int unsigned           pending;
  int unsigned           errors;

  int                    tx_idle_pct   = 0;
  int                    rx_idle_pct   = 0;
  int                    hold_requests = 0;
  int                    moist_walk    = 2000;
  logic [TIME_W-1:0]     clock_ms      = '0;

  phsc_item_if   item_bus();
  phsc_result_if res_bus();

  pump_hysteresis_safety_controller #(
    .MAX_RUN_MS(RUN_LIMIT_MS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus),
    .result   (res_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  phsc_checker #(
    .RUN_LIMIT_MS(RUN_LIMIT_MS)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus),
    .result   (res_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("pump_hysteresis_safety_controller: mismatch");
    $finish;
  end

  // Result side: random backpressure, plus long hold-offs on request
  initial begin : receiver
    int holds_done = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Returns at the edge of the transfer with valid still high
  task automatic offer(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.kind         <= it.kind;
    item_bus.moisture_raw <= it.moisture_raw;
    item_bus.ph_raw       <= it.ph_raw;
    item_bus.sensor_fault <= it.sensor_fault;
    item_bus.water_ok     <= it.water_ok;
    item_bus.time_ms      <= it.time_ms;
    item_bus.has_mode     <= it.has_mode;
    item_bus.mode_manual  <= it.mode_manual;
    item_bus.has_pump_cmd <= it.has_pump_cmd;
    item_bus.pump_cmd_on  <= it.pump_cmd_on;
    item_bus.estop        <= it.estop;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  task automatic drain();
    int waited = 0;
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    // a control item may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cal(input int m_min, m_target, p_min, p_max, dry, wet, r4, r7);
    reg_set_t vals;
    vals[CFG_MOISTURE_MIN]    = CFG_DATA_W'(m_min);
    vals[CFG_MOISTURE_TARGET] = CFG_DATA_W'(m_target);
    vals[CFG_PH_MIN]          = CFG_DATA_W'(p_min);
    vals[CFG_PH_MAX]          = CFG_DATA_W'(p_max);
    vals[CFG_MOIST_DRY]       = CFG_DATA_W'(dry);
    vals[CFG_MOIST_WET]       = CFG_DATA_W'(wet);
    vals[CFG_PH_RAW_4]        = CFG_DATA_W'(r4);
    vals[CFG_PH_RAW_7]        = CFG_DATA_W'(r7);
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_IDX_W'(i);
      wr_data  <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_sample(input logic [RAW_W-1:0] m, p, input logic sf, wok,
                             input logic [TIME_W-1:0] t);
    item_t it;
    it              = {$urandom(), $urandom()};
    it.kind         = KIND_SAMPLE;
    it.moisture_raw = m;
    it.ph_raw       = p;
    it.sensor_fault = sf;
    it.water_ok     = wok;
    it.time_ms      = t;
    offer(it);
  endtask

  task automatic send_control(input logic hm, mm, hc, co, es);
    item_t it;
    it              = {$urandom(), $urandom()};
    it.kind         = KIND_CONTROL;
    it.has_mode     = hm;
    it.mode_manual  = mm;
    it.has_pump_cmd = hc;
    it.pump_cmd_on  = co;
    it.estop        = es;
    offer(it);
  endtask

  // Mostly clean samples with drifting moisture and a mostly advancing clock,
  // with some controls, faults and clock jumps mixed in
  function automatic item_t random_item();
    item_t it;
    int    pick;
    it = {$urandom(), $urandom()};
    if ($urandom_range(99) < 15) begin
      it.kind         = KIND_CONTROL;
      it.has_mode     = ($urandom_range(99) < 30);
      it.has_pump_cmd = ($urandom_range(99) < 40);
      it.estop        = ($urandom_range(99) < 20);
    end else begin
      it.kind = KIND_SAMPLE;
      if ($urandom_range(99) < 8) moist_walk = $urandom_range(4095);
      else moist_walk += int'($urandom_range(160)) - 80;
      if (moist_walk < 0) moist_walk = 0;
      else if (moist_walk > 4095) moist_walk = 4095;
      it.moisture_raw = moist_walk[RAW_W-1:0];
      it.sensor_fault = ($urandom_range(99) < 8);
      it.water_ok     = ($urandom_range(99) >= 8);
      pick = $urandom_range(99);
      if (pick < 2) clock_ms = $urandom();
      else if (pick < 10) clock_ms += $urandom_range(400000, 250000);
      else if (pick < 40) clock_ms += $urandom_range(60000);
      else clock_ms += $urandom_range(3000);
      it.time_ms = clock_ms;
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) offer(random_item());
  endtask

  initial begin : stimulus
    wr_en                 <= 1'b0;
    wr_index              <= '0;
    wr_data               <= '0;
    item_bus.valid        <= 1'b0;
    item_bus.kind         <= KIND_SAMPLE;
    item_bus.moisture_raw <= '0;
    item_bus.ph_raw       <= '0;
    item_bus.sensor_fault <= 1'b0;
    item_bus.water_ok     <= 1'b0;
    item_bus.time_ms      <= '0;
    item_bus.has_mode     <= 1'b0;
    item_bus.mode_manual  <= 1'b0;
    item_bus.has_pump_cmd <= 1'b0;
    item_bus.pump_cmd_on  <= 1'b0;
    item_bus.estop        <= 1'b0;
    rst                   <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 38;
    rx_idle_pct = 68;

    // Directed part on the reset calibration
    send_sample(12'd0, 12'd0, 1'b0, 1'b1, 32'd0);
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1, 32'd1000);
    send_sample(12'd2190, 12'd1766, 1'b0, 1'b1, 32'd2000);   // on the minimum: hold
    send_sample(12'd1830, 12'd1500, 1'b0, 1'b1, 32'd3000);   // on the target: off
    send_sample(12'd2190, 12'd2032, 1'b0, 1'b1, 32'd4000);
    send_sample(12'd4095, 12'd0, 1'b1, 1'b1, 32'd5000);
    send_sample(12'd4095, 12'd0, 1'b1, 1'b0, 32'd6000);
    send_control(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_sample(12'd4095, 12'd0, 1'b1, 1'b0, 32'd7000);
    send_sample(12'd4095, 12'd0, 1'b0, 1'b1, 32'd8000);      // stop cleared, pump on
    send_sample(12'd4095, 12'd0, 1'b0, 1'b1, 32'd307999);
    send_sample(12'd4095, 12'd0, 1'b0, 1'b1, 32'd308000);    // runtime limit
    send_sample(12'd4095, 12'd0, 1'b0, 1'b1, 32'd308000);
    send_control(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(12'd4095, 12'd1200, 1'b0, 1'b1, 32'd309000);
    send_control(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_sample(12'd0, 12'd1200, 1'b1, 1'b1, 32'd310000);
    send_sample(12'd0, 12'd1200, 1'b0, 1'b1, 32'd311000);
    send_control(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_sample(12'd0, 12'd1200, 1'b0, 1'b1, 32'd312000);
    send_control(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1, 32'hFFFF_FFF0);
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1, 32'h0004_93CF);  // wrapped, just short
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1, 32'h0004_93D0);
    send_control(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1, 32'hFFFF_FFFF);

    clock_ms = 32'h0100_0000;
    run_random(200);
    drain();

    // rising moisture curve, widest pH window
    set_cal(20, 80, 0, 1400, 0, 4095, 4095, 0);
    run_random(60);
    hold_requests++;
    run_random(140);
    drain();

    tx_idle_pct = 68;
    rx_idle_pct = 38;
    // both calibration spans flat, empty pH window
    set_cal(0, 100, 1400, 0, 4095, 4095, 1000, 1000);
    run_random(150);
    drain();

    set_cal(100, 100, 400, 1000, 3500, 500, 2800, 1200);
    run_random(100);
    drain();
    run_random(100);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // all-ones threshold data: thresholds land above their stated ranges
    set_cal(4095, 4095, 4095, 4095, 4095, 0, 0, 4095);
    run_random(200);
    drain();

    set_cal($urandom_range(100), $urandom_range(100), $urandom_range(1400),
            $urandom_range(1400), $urandom_range(4095), $urandom_range(4095),
            $urandom_range(4095), $urandom_range(4095));
    run_random(250);
    drain();

    if (pending != 0) $error("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("pump_hysteresis_safety_controller: match");
    end else begin
      $display("pump_hysteresis_safety_controller: mismatch");
    end
    $finish;
  end

endmodule
